// ===== rtl/md5bc_pkg.sv =====
`default_nettype none

package md5bc_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
        logic [63:0] bytes_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PRIME,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [63:0] BLOCK_BYTES = 64'd64;
    localparam logic [5:0]  LAST_STEP   = 6'd63;
    localparam logic [3:0]  LAST_WORD   = 4'd15;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word index used by a given step.
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] s;
        logic [3:0] idx;
        s = step[3:0];
        unique case (step[5:4])
            2'd0: idx = s;
            2'd1: idx = 4'(s * 4'd5 + 4'd1);
            2'd2: idx = 4'(s * 4'd3 + 4'd5);
            default: idx = 4'(s * 4'd7);
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] amt;
        unique case ({step[5:4], step[1:0]})
            4'h0: amt = 5'd7;
            4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;
            4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;
            4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;
            4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;
            4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;
            4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;
            4'hd: amt = 5'd10;
            4'he: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (rnd)
            2'd0: f = d ^ (b & (c ^ d));
            2'd1: f = c ^ (d & (b ^ c));
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_block_compress_core.sv =====
`default_nettype none

// Channel   Direction  Payload     Handshake
// in        sink       t_in_item   i_in_valid / o_in_stall
// out       source     t_out_item  o_out_valid / i_out_stall
//
// Each message word takes one cycle while a block is being collected. After the
// sixteenth transfer the input stalls while the block is compressed: the block memory
// read is primed, the 64 MD5 steps run (the next schedule word read alongside each),
// the working words fold into the chaining words and the output register is loaded.
// The core holds in that last state while an earlier result still waits.
// Reset loads the standard chaining words, clears byte count and word index, not memory.

module md5_block_compress_core
    import md5bc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_state      r_state, n_state;

    // Block memory: one write port for collection, one registered read port.
    logic [31:0] r_block_words [16];
    logic [31:0] r_rdata;
    logic [3:0]  n_rd_addr;

    logic [3:0]  r_word_index;
    logic [5:0]  r_step;
    logic [31:0] r_chain_a, r_chain_b, r_chain_c, r_chain_d;
    logic [31:0] r_wa, r_wb, r_wc, r_wd;
    logic [63:0] r_byte_total;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        in_xfer;
    logic        out_xfer;
    logic        load_work;
    logic        do_round;
    logic        do_fold;
    logic        load_out;
    logic [3:0]  wr_index;
    logic [31:0] f_val;
    logic [31:0] t_sum;
    logic [31:0] n_wb;

    assign o_in_stall  = (r_state != ST_COLLECT);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A restart word lands at the head of a fresh block.
    assign wr_index = i_in_data.restart ? 4'd0 : r_word_index;

    // One MD5 step on the working words.
    assign f_val = round_fn(r_step[5:4], r_wb, r_wc, r_wd);
    assign t_sum = r_wa + f_val + r_rdata + SINE_K[r_step];
    assign n_wb  = r_wb + rotl32(t_sum, rot_amount(r_step));

    always_comb begin
        n_state   = r_state;
        n_rd_addr = msg_index(6'(r_step + 6'd1));
        load_work = 1'b0;
        do_round  = 1'b0;
        do_fold   = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_xfer && wr_index == LAST_WORD) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                // Fetch the first schedule word and take a copy of the chain.
                n_rd_addr = msg_index(6'd0);
                load_work = 1'b1;
                n_state   = ST_ROUND;
            end
            ST_ROUND: begin
                do_round = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                do_fold = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free.
                if (!r_out_valid || out_xfer) begin
                    load_out = 1'b1;
                    n_state  = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_block_words[wr_index] <= i_in_data.msg_word;
        end
        r_rdata <= r_block_words[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
            r_byte_total <= '0;
            r_chain_a    <= IV_A;
            r_chain_b    <= IV_B;
            r_chain_c    <= IV_C;
            r_chain_d    <= IV_D;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_word_index <= 4'(wr_index + 4'd1);
                if (i_in_data.restart) begin
                    r_chain_a    <= IV_A;
                    r_chain_b    <= IV_B;
                    r_chain_c    <= IV_C;
                    r_chain_d    <= IV_D;
                    r_byte_total <= '0;
                end
            end
            if (load_work) begin
                r_step <= '0;
            end else if (do_round) begin
                r_step <= 6'(r_step + 6'd1);
            end
            if (do_fold) begin
                r_chain_a    <= r_chain_a + r_wa;
                r_chain_b    <= r_chain_b + r_wb;
                r_chain_c    <= r_chain_c + r_wc;
                r_chain_d    <= r_chain_d + r_wd;
                r_byte_total <= r_byte_total + BLOCK_BYTES;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working words and output payload need no reset.
    always_ff @(posedge i_clk) begin
        if (load_work) begin
            r_wa <= r_chain_a;
            r_wb <= r_chain_b;
            r_wc <= r_chain_c;
            r_wd <= r_chain_d;
        end else if (do_round) begin
            r_wa <= r_wd;
            r_wd <= r_wc;
            r_wc <= r_wb;
            r_wb <= n_wb;
        end
        if (load_out) begin
            r_out_data.digest_a   <= r_chain_a;
            r_out_data.digest_b   <= r_chain_b;
            r_out_data.digest_c   <= r_chain_c;
            r_out_data.digest_d   <= r_chain_d;
            r_out_data.bytes_done <= r_byte_total;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import md5bc_pkg::t_in_item;
    import md5bc_pkg::t_out_item;

    // Run shape
    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_ITEMS   = 150;     // tail of the run with no idling on either side
    localparam int LONG_HOLD    = 400;     // receiver hold-off, well beyond one block time
    localparam int PAUSE_BLOCK  = 40;      // block after which the sender waits for the digests
    localparam int DRAIN_CYCLES = 100;     // one block compression plus margin
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 50;

    // Standard chaining seed words
    localparam logic [31:0] SEED_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Additive constant of every step: floor(abs(sin(i + 1)) * 2^32)
    localparam logic [31:0] ADD_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts, indexed by round * 4 + (step mod 4)
    localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Message word schedule per round: index = (ofs + mul * step) mod 16
    localparam int SCHED_MUL [4] = '{1, 5, 3, 7};
    localparam int SCHED_OFS [4] = '{0, 1, 5, 0};

    // Directed transfers. Rows 0-3 start a block that the restart on row 4 drops;
    // rows 4-19 are the padded empty message, whose digest is well known; rows
    // 20-23 are dropped again by the restart on row 24.
    localparam int DIR_ROWS  = 25;
    localparam int EMPTY_ROW = 19;
    localparam logic [31:0] DIR_WORD [DIR_ROWS] = '{
        32'hffffffff, 32'h00000000, 32'hffffffff, 32'h0000ffff,
        32'h00000080, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'hffffffff, 32'h00000000, 32'hffffffff, 32'h80000000,
        32'h00000001
    };
    localparam bit DIR_RESTART [DIR_ROWS] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };
    // Digest of the empty message, as little-endian words, after one 64-byte block
    localparam t_out_item EMPTY_MSG_DIGEST = {
        32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec, 64'd64
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    // Predictor state: chaining words, byte count, collected block and fill level
    logic [31:0] hash_st [4];
    logic [63:0] byte_cnt;
    logic [31:0] blk [16];
    logic [3:0]  fill;

    t_out_item pending_digests [$];

    int  fail_count   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;
    bit  held_long    = 1'b0;

    md5_block_compress_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one
    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0d] %s", cycle_count, msg);
        fail_count++;
    endtask

    // Absorb one accepted word; on the sixteenth word of a block run the 64 steps,
    // fold into the chaining words and hand back the digest with the byte count.
    task automatic absorb_word(input t_in_item it, output bit has_res, output t_out_item res);
        logic [31:0] va, vb, vc, vd, mix, acc;
        int          rnd, widx, amt;
        if (it.restart) begin
            for (int k = 0; k < 4; k++)
                hash_st[k] = SEED_WORDS[k];
            byte_cnt = '0;
            fill     = '0;
        end
        blk[fill] = it.msg_word;
        fill      = fill + 4'd1;
        has_res   = (fill == 4'd0);
        res       = '0;
        if (has_res) begin
            va = hash_st[0];
            vb = hash_st[1];
            vc = hash_st[2];
            vd = hash_st[3];
            for (int s = 0; s < 64; s++) begin
                rnd = s / 16;
                case (rnd)
                    0: mix = vd ^ (vb & (vc ^ vd));
                    1: mix = vc ^ (vd & (vb ^ vc));
                    2: mix = vb ^ vc ^ vd;
                    default: mix = vc ^ (vb | ~vd);
                endcase
                widx = (SCHED_OFS[rnd] + SCHED_MUL[rnd] * s) % 16;
                amt  = ROT_TAB[rnd * 4 + s % 4];
                acc  = va + mix + blk[widx] + ADD_K[s];
                acc  = vb + ((acc << amt) | (acc >> (32 - amt)));
                va = vd;
                vd = vc;
                vc = vb;
                vb = acc;
            end
            hash_st[0] += va;
            hash_st[1] += vb;
            hash_st[2] += vc;
            hash_st[3] += vd;
            byte_cnt   += 64'd64;
            res = {hash_st[0], hash_st[1], hash_st[2], hash_st[3], byte_cnt};
        end
    endtask

    // Bias towards the extremes and single set or cleared bits now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Offer one word from the falling edge and hold it until the transfer; return
    // just after the accepting rising edge. A typed digest, where given, replaces
    // the predicted one in the queue.
    task automatic send_word(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        has_res;
        t_out_item res;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        absorb_word(it, has_res, res);
        if (has_res)
            pending_digests.push_back(typed ? typed_res : res);
    endtask

    // Cycle counter and watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off once results flow, none in the tail
    initial begin
        @(negedge clk);
        forever begin
            if (!held_long && results_seen >= 6) begin
                // hold off long enough for the block to fill and stall its input
                held_long = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // Result checker: compare each transfer field by field with the oldest digest due
    always @(posedge clk) begin : digest_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_digests.size() == 0) begin
                note_failure($sformatf("result with nothing due: %h", out_data));
            end else begin
                want = pending_digests.pop_front();
                if (out_data.digest_a !== want.digest_a)
                    note_failure($sformatf("digest_a %h, due %h", out_data.digest_a,
                                           want.digest_a));
                if (out_data.digest_b !== want.digest_b)
                    note_failure($sformatf("digest_b %h, due %h", out_data.digest_b,
                                           want.digest_b));
                if (out_data.digest_c !== want.digest_c)
                    note_failure($sformatf("digest_c %h, due %h", out_data.digest_c,
                                           want.digest_c));
                if (out_data.digest_d !== want.digest_d)
                    note_failure($sformatf("digest_d %h, due %h", out_data.digest_d,
                                           want.digest_d));
                if (out_data.bytes_done !== want.bytes_done)
                    note_failure($sformatf("bytes_done %0d, due %0d", out_data.bytes_done,
                                           want.bytes_done));
            end
        end
    end

    // Stimulus
    initial begin
        t_in_item word;
        int       random_sent;
        int       blocks_done;
        int       n;
        bit       first;
        bit       realign;

        random_sent = 0;
        blocks_done = 0;
        realign     = 1'b0;
        for (int k = 0; k < 4; k++)
            hash_st[k] = SEED_WORDS[k];
        byte_cnt = '0;
        fill     = '0;

        // hold reset, then release it on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int row = 0; row < DIR_ROWS; row++) begin
            word.msg_word = DIR_WORD[row];
            word.restart  = DIR_RESTART[row];
            send_word(word, row == EMPTY_ROW, EMPTY_MSG_DIGEST);
        end

        // Random part: mostly whole blocks with random content, some broken runs
        while (random_sent < RANDOM_ITEMS) begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 9) == 0) begin
                // noise: a short run with stray restarts; realign on the next block
                n = $urandom_range(1, 15);
                repeat (n) begin
                    word.msg_word = pick_word();
                    word.restart  = ($urandom_range(0, 7) == 0);
                    send_word(word, 1'b0, '0);
                    random_sent++;
                end
                realign = 1'b1;
            end else begin
                // complete the block in hand, or a fresh one after a restart
                first = 1'b1;
                do begin
                    word.msg_word = pick_word();
                    word.restart  = first && (realign || $urandom_range(0, 3) == 0);
                    send_word(word, 1'b0, '0);
                    first = 1'b0;
                    random_sent++;
                end while (fill != 4'd0);
                realign = 1'b0;
                blocks_done++;
                if (blocks_done == PAUSE_BLOCK) begin
                    // drop valid and wait until every digest due has arrived
                    @(negedge clk);
                    in_valid <= 1'b0;
                    do @(negedge clk); while (pending_digests.size() != 0);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_digests.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/md5bc_pkg.sv
rtl/md5_block_compress_core.sv
tb/sv/testbench.sv
